// ===== hdl/dds_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_pkg: shared types and constants of the door drive sequencer
// Door state codes, request kinds, register indexes, reset values and the
// structs that carry control state, configuration and one response.
// ----------------------------------------------------------------------------
package dds_pkg;

   // Default width of tracked position and travel limit
   localparam int POSITION_BITS_DEF = 22;

   // Door state codes
   localparam logic [2:0] ST_OPEN    = 3'd0;
   localparam logic [2:0] ST_CLOSED  = 3'd1;
   localparam logic [2:0] ST_OPENING = 3'd2;
   localparam logic [2:0] ST_CLOSING = 3'd3;
   localparam logic [2:0] ST_STOPPED = 3'd4;

   // Request kinds carried on tuser
   localparam logic [1:0] MODE_TOGGLE = 2'd0;
   localparam logic [1:0] MODE_TICK   = 2'd1;
   localparam logic [1:0] MODE_CAL    = 2'd2;

   // Register indexes
   localparam logic [1:0] CSR_MOVE_THRESH = 2'd0;
   localparam logic [1:0] CSR_TIMEOUT     = 2'd1;
   localparam logic [1:0] CSR_STEPS       = 2'd2;
   localparam logic [1:0] CSR_END_OFFSET  = 2'd3;

   // Register reset values
   localparam logic [15:0] MOVE_THRESH_RST = 16'd4;
   localparam logic [15:0] TIMEOUT_RST     = 16'd1000;
   localparam logic [9:0]  STEPS_RST       = 10'd8;
   localparam logic [19:0] END_OFFSET_RST  = 20'd740;

   // Packed widths on the stream ports
   localparam int REQ_DATA_BITS = 80;
   localparam int RSP_DATA_BITS = 24;
   localparam int CSR_DATA_BITS = 20;

   typedef struct packed {
      logic [15:0] move_thresh;
      logic [15:0] timeout_ms;
      logic [9:0]  steps;
      logic [19:0] end_offset;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         status;
      logic [2:0]         prev_end;
      logic               calibrated;
      logic               stuck;
      logic signed [23:0] ref_count;
      logic [31:0]        move_time;
   } ctl_type;

   typedef struct packed {
      logic               calibrated_flag;
      logic               stuck_flag;
      logic [2:0]         door_state;
      logic               encoder_clear;
      logic               motor_stop;
      logic signed [10:0] motor_steps;
   } rsp_type;

endpackage

// ===== hdl/door_drive_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// door_drive_sequencer_top: stepper door drive sequencer
// Request register, single-pass sequencing logic, response register.
// ----------------------------------------------------------------------------
// Order: a request is held in the request register, then its response in the response register.
// Throughput: one request per cycle; the request register and the response
//   register each advance whenever the response register is empty or taken.
// Reset: synchronous, active high; door closed, uncalibrated, not stuck,
//   position and limit zero, registers at their default values.
module door_drive_sequencer_top #(
   parameter int POSITION_BITS = dds_pkg::POSITION_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request stream
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [23:0] encoder_count, [55:24] time_ms, [75:56] closing_travel_steps
   input  logic [dds_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // [1:0] mode
   input  logic [1:0]                        req_tuser,
   // response stream
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [10:0] motor_steps, [11] motor_stop, [12] encoder_clear,
   // [15:13] door_state, [16] stuck_flag, [17] calibrated_flag
   output logic [dds_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // register writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [1:0]                        csr_index,
   input  logic [dds_pkg::CSR_DATA_BITS-1:0] csr_data
);

   localparam int PB = POSITION_BITS;

   logic                     in_vld_ff;
   logic [1:0]               mode_ff;
   logic signed [23:0]       enc_ff;
   logic [31:0]              time_ff;
   logic [19:0]              cts_ff;
   logic                     advance;

   dds_pkg::cfg_type         cfg_ff;
   dds_pkg::ctl_type         ctl_ff;
   dds_pkg::ctl_type         ctl_in;
   logic signed [PB-1:0]     pos_ff;
   logic signed [PB-1:0]     pos_in;
   logic signed [PB-1:0]     lim_ff;
   logic signed [PB-1:0]     lim_in;
   dds_pkg::rsp_type         rsp_in;
   dds_pkg::rsp_type         rsp_ff;
   logic                     rsp_vld_ff;

   assign advance    = in_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !in_vld_ff || advance;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {6'd0, rsp_ff};

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.move_thresh <= dds_pkg::MOVE_THRESH_RST;
         cfg_ff.timeout_ms  <= dds_pkg::TIMEOUT_RST;
         cfg_ff.steps       <= dds_pkg::STEPS_RST;
         cfg_ff.end_offset  <= dds_pkg::END_OFFSET_RST;
      end else if (csr_valid) begin
         unique case (csr_index)
            dds_pkg::CSR_MOVE_THRESH: cfg_ff.move_thresh <= csr_data[15:0];
            dds_pkg::CSR_TIMEOUT:     cfg_ff.timeout_ms  <= csr_data[15:0];
            dds_pkg::CSR_STEPS:       cfg_ff.steps       <= csr_data[9:0];
            dds_pkg::CSR_END_OFFSET:  cfg_ff.end_offset  <= csr_data[19:0];
            default:                  cfg_ff.end_offset  <= cfg_ff.end_offset;
         endcase
      end
   end

   // Capture the request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (req_tready) begin
         in_vld_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         mode_ff <= req_tuser;
         enc_ff  <= req_tdata[23:0];
         time_ff <= req_tdata[55:24];
         cts_ff  <= req_tdata[75:56];
      end
   end

   dds_step #(
      .POSITION_BITS (PB)
   ) u_step (
      .mode                 (mode_ff),
      .encoder_count        (enc_ff),
      .time_ms              (time_ff),
      .closing_travel_steps (cts_ff),
      .cfg                  (cfg_ff),
      .ctl_cur              (ctl_ff),
      .pos_cur              (pos_ff),
      .lim_cur              (lim_ff),
      .ctl_nxt              (ctl_in),
      .pos_nxt              (pos_in),
      .lim_nxt              (lim_in),
      .rsp                  (rsp_in)
   );

   // Commit door state as the request moves into the response register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.status     <= dds_pkg::ST_CLOSED;
         ctl_ff.prev_end   <= dds_pkg::ST_CLOSED;
         ctl_ff.calibrated <= 1'b0;
         ctl_ff.stuck      <= 1'b0;
         ctl_ff.ref_count  <= '0;
         ctl_ff.move_time  <= '0;
         pos_ff            <= '0;
         lim_ff            <= '0;
      end else if (advance) begin
         ctl_ff <= ctl_in;
         pos_ff <= pos_in;
         lim_ff <= lim_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (advance) begin
         rsp_vld_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   // Stuck flag stays set until reset
   a_stuck_sticky: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.stuck |=> ctl_ff.stuck)
      else $error("stuck flag cleared without reset");

   // A stop command never comes with an encoder clear
   a_stop_no_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_vld_ff |-> !(rsp_ff.motor_stop && rsp_ff.encoder_clear))
      else $error("stop and encoder clear in one response");

   // Calibration leaves the door closed and calibrated
   a_cal_closed: assert property (@(posedge clock) disable iff (reset)
      advance && (mode_ff == dds_pkg::MODE_CAL) |=>
         ctl_ff.calibrated && (ctl_ff.status == dds_pkg::ST_CLOSED) && (pos_ff == '0))
      else $error("calibration did not close the door");

   // A request leaving the request register yields a response
   a_advance_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_vld_ff)
      else $error("response lost after advance");

endmodule

// ===== hdl/dds_step.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_step: next-state and response logic for one request
// Takes the registered request, the control state, position and limit, and
// produces the updated state together with the response fields.
// ----------------------------------------------------------------------------
module dds_step #(
   parameter int POSITION_BITS = dds_pkg::POSITION_BITS_DEF
) (
   input  logic [1:0]                       mode,
   input  logic signed [23:0]               encoder_count,
   input  logic [31:0]                      time_ms,
   input  logic [19:0]                      closing_travel_steps,
   input  dds_pkg::cfg_type                 cfg,
   input  dds_pkg::ctl_type                 ctl_cur,
   input  logic signed [POSITION_BITS-1:0]  pos_cur,
   input  logic signed [POSITION_BITS-1:0]  lim_cur,
   output dds_pkg::ctl_type                 ctl_nxt,
   output logic signed [POSITION_BITS-1:0]  pos_nxt,
   output logic signed [POSITION_BITS-1:0]  lim_nxt,
   output dds_pkg::rsp_type                 rsp
);

   localparam int PB = POSITION_BITS;
   localparam int LW = (PB > 22) ? PB : 22;
   localparam logic signed [LW-1:0] POS_HI = LW'((64'd1 << (PB - 1)) - 64'd1);
   localparam logic signed [LW-1:0] POS_LO = ~POS_HI;
   localparam logic signed [PB-1:0] POS_MAX = PB'((64'd1 << (PB - 1)) - 64'd1);
   localparam logic signed [PB-1:0] POS_MIN = ~POS_MAX;
   localparam logic signed [PB-1:0] POS_ZERO = '0;

   logic                     moving;
   logic                     opening;
   logic signed [PB:0]       pos_sum;
   logic signed [PB-1:0]     pos_step;
   logic signed [21:0]       lim_dif;
   logic signed [LW-1:0]     lim_dif_w;
   logic signed [PB-1:0]     lim_cal;
   logic signed [24:0]       enc_dif;
   logic [24:0]              enc_mag;
   logic                     moved;
   logic [31:0]              idle_ms;
   logic                     timed_out;
   logic                     reached;
   logic [2:0]               open_start;
   logic [2:0]               close_start;
   logic [2:0]               end_state;

   // Advance position by one batch of steps, saturating at the range
   always_comb begin
      moving  = (ctl_cur.status == dds_pkg::ST_OPENING) ||
                (ctl_cur.status == dds_pkg::ST_CLOSING);
      opening = (ctl_cur.status == dds_pkg::ST_OPENING);
      if (opening) begin
         pos_sum = {pos_cur[PB-1], pos_cur} - $signed({1'b0, PB'(cfg.steps)});
      end else begin
         pos_sum = {pos_cur[PB-1], pos_cur} + $signed({1'b0, PB'(cfg.steps)});
      end
      if (pos_sum[PB] != pos_sum[PB-1]) begin
         pos_step = pos_sum[PB] ? POS_MIN : POS_MAX;
      end else begin
         pos_step = pos_sum[PB-1:0];
      end
   end

   // Travel limit from a calibration, saturated to the position range
   always_comb begin
      lim_dif   = $signed({2'b00, cfg.end_offset}) - $signed({2'b00, closing_travel_steps});
      lim_dif_w = LW'(lim_dif);
      if (lim_dif_w > POS_HI) begin
         lim_cal = POS_MAX;
      end else if (lim_dif_w < POS_LO) begin
         lim_cal = POS_MIN;
      end else begin
         lim_cal = lim_dif_w[PB-1:0];
      end
   end

   // Movement and stall checks
   always_comb begin
      enc_dif   = {encoder_count[23], encoder_count} -
                  {ctl_cur.ref_count[23], ctl_cur.ref_count};
      enc_mag   = enc_dif[24] ? 25'(-enc_dif) : 25'(enc_dif);
      moved     = (enc_mag >= {9'd0, cfg.move_thresh});
      idle_ms   = time_ms - ctl_cur.move_time;
      timed_out = (idle_ms >= {16'd0, cfg.timeout_ms});
      reached   = opening ? (pos_step < lim_cur) : (pos_step > POS_ZERO);
      end_state = opening ? dds_pkg::ST_OPEN : dds_pkg::ST_CLOSED;
      open_start  = (pos_cur >= lim_cur) ? dds_pkg::ST_OPENING : dds_pkg::ST_OPEN;
      close_start = (pos_cur <= POS_ZERO) ? dds_pkg::ST_CLOSING : dds_pkg::ST_CLOSED;
   end

   // Sequence the door for this request
   always_comb begin
      ctl_nxt           = ctl_cur;
      pos_nxt           = pos_cur;
      lim_nxt           = lim_cur;
      rsp.motor_steps   = '0;
      rsp.motor_stop    = 1'b0;
      rsp.encoder_clear = 1'b0;
      unique case (mode)
         dds_pkg::MODE_TOGGLE: begin
            if (ctl_cur.calibrated) begin
               unique case (ctl_cur.status)
                  dds_pkg::ST_OPEN: begin
                     ctl_nxt.prev_end  = dds_pkg::ST_OPEN;
                     ctl_nxt.status    = close_start;
                     ctl_nxt.ref_count = '0;
                     ctl_nxt.move_time = time_ms;
                     rsp.encoder_clear = 1'b1;
                  end
                  dds_pkg::ST_CLOSED: begin
                     ctl_nxt.prev_end  = dds_pkg::ST_CLOSED;
                     ctl_nxt.status    = open_start;
                     ctl_nxt.ref_count = '0;
                     ctl_nxt.move_time = time_ms;
                     rsp.encoder_clear = 1'b1;
                  end
                  dds_pkg::ST_OPENING, dds_pkg::ST_CLOSING: begin
                     ctl_nxt.status = dds_pkg::ST_STOPPED;
                     rsp.motor_stop = 1'b1;
                  end
                  default: begin
                     // resume toward the end the door last left
                     ctl_nxt.status    = (ctl_cur.prev_end == dds_pkg::ST_OPEN) ?
                                         open_start : close_start;
                     ctl_nxt.ref_count = '0;
                     ctl_nxt.move_time = time_ms;
                     rsp.encoder_clear = 1'b1;
                  end
               endcase
            end
         end
         dds_pkg::MODE_TICK: begin
            if (moving) begin
               rsp.motor_steps = opening ? (11'sd0 - $signed({1'b0, cfg.steps})) :
                                           $signed({1'b0, cfg.steps});
               pos_nxt = pos_step;
               if (moved) begin
                  ctl_nxt.ref_count = encoder_count;
                  ctl_nxt.move_time = time_ms;
                  if (reached) begin
                     ctl_nxt.status = end_state;
                  end
               end else if (timed_out) begin
                  rsp.motor_stop     = 1'b1;
                  ctl_nxt.stuck      = 1'b1;
                  ctl_nxt.calibrated = 1'b0;
                  ctl_nxt.status     = end_state;
               end else if (reached) begin
                  ctl_nxt.status = end_state;
               end
            end
         end
         dds_pkg::MODE_CAL: begin
            lim_nxt            = lim_cal;
            pos_nxt            = '0;
            ctl_nxt.status     = dds_pkg::ST_CLOSED;
            ctl_nxt.prev_end   = dds_pkg::ST_CLOSED;
            ctl_nxt.calibrated = 1'b1;
            ctl_nxt.ref_count  = '0;
            rsp.encoder_clear  = 1'b1;
         end
         default: begin
            // unused kind: no action
         end
      endcase
      rsp.door_state      = ctl_nxt.status;
      rsp.stuck_flag      = ctl_nxt.stuck;
      rsp.calibrated_flag = ctl_nxt.calibrated;
   end

endmodule

// ===== sim/tb_door_drive_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_door_drive_sequencer_top: self-checking bench for the door drive sequencer
// Drives button, tick, calibration and unused-kind requests with random gaps
// and response stalls, predicts every response from a local model of the door
// sequencing, and compares each response field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_door_drive_sequencer_top;

   // Unused kind code, on which the block takes no action
   localparam logic [1:0] MODE_NONE = 2'd3;
   localparam int POS_BITS = dds_pkg::POSITION_BITS_DEF;
   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_ITEMS = 75;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [dds_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic [1:0] req_tuser = dds_pkg::MODE_TOGGLE;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [dds_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = dds_pkg::CSR_MOVE_THRESH;
   logic [dds_pkg::CSR_DATA_BITS-1:0] csr_data = '0;

   // Local copy of the registers
   logic [15:0] cfg_thresh = dds_pkg::MOVE_THRESH_RST;
   logic [15:0] cfg_timeout = dds_pkg::TIMEOUT_RST;
   logic [9:0] cfg_steps = dds_pkg::STEPS_RST;
   logic [19:0] cfg_offset = dds_pkg::END_OFFSET_RST;

   // Local copy of the door state
   logic [2:0] door_st = dds_pkg::ST_CLOSED;
   logic [2:0] prev_end = dds_pkg::ST_CLOSED;
   bit door_calibrated = 1'b0;
   bit door_stuck = 1'b0;
   longint door_pos = 0;
   longint travel_lim = 0;
   longint ref_cnt = 0;
   logic [31:0] move_time = '0;

   // Responses still owed by the block, oldest first
   dds_pkg::rsp_type rsp_due [$];

   int error_count = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit quiet = 1'b0;
   logic [31:0] now_ms = '0;

   door_drive_sequencer_top dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Door sequencing model
   // ------------------------------------------------------------------

   // Clamp to the signed position range
   function automatic longint clamp_pos(longint v);
      longint hi;
      hi = (longint'(1) <<< (POS_BITS - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
   endfunction

   // Start a move; the end state is taken at once when nothing is left to travel
   function automatic void begin_travel(logic [2:0] dir, logic [31:0] now);
      ref_cnt = 0;
      move_time = now;
      if (dir == dds_pkg::ST_OPENING)
         door_st = (door_pos >= travel_lim) ? dds_pkg::ST_OPENING : dds_pkg::ST_OPEN;
      else
         door_st = (door_pos <= 0) ? dds_pkg::ST_CLOSING : dds_pkg::ST_CLOSED;
   endfunction

   function automatic dds_pkg::rsp_type door_step(logic [1:0] mode, logic [23:0] enc,
                                                  logic [31:0] now, logic [19:0] cs);
      dds_pkg::rsp_type r;
      longint steps;
      longint d;
      longint offs;
      longint cnt;
      bit opening;
      bit past_end;
      logic [31:0] elapsed;
      r = '0;
      steps = 0;
      cnt = longint'($signed(enc));
      case (mode)
         dds_pkg::MODE_TOGGLE: begin
            if (door_calibrated) begin
               case (door_st)
                  dds_pkg::ST_OPEN: begin
                     prev_end = dds_pkg::ST_OPEN;
                     begin_travel(dds_pkg::ST_CLOSING, now);
                     r.encoder_clear = 1'b1;
                  end
                  dds_pkg::ST_CLOSED: begin
                     prev_end = dds_pkg::ST_CLOSED;
                     begin_travel(dds_pkg::ST_OPENING, now);
                     r.encoder_clear = 1'b1;
                  end
                  dds_pkg::ST_OPENING, dds_pkg::ST_CLOSING: begin
                     door_st = dds_pkg::ST_STOPPED;
                     r.motor_stop = 1'b1;
                  end
                  default: begin
                     begin_travel((prev_end == dds_pkg::ST_OPEN) ?
                                  dds_pkg::ST_OPENING : dds_pkg::ST_CLOSING, now);
                     r.encoder_clear = 1'b1;
                  end
               endcase
            end
         end
         dds_pkg::MODE_TICK: begin
            if (door_st == dds_pkg::ST_OPENING || door_st == dds_pkg::ST_CLOSING) begin
               opening = (door_st == dds_pkg::ST_OPENING);
               steps = opening ? -longint'(cfg_steps) : longint'(cfg_steps);
               door_pos = clamp_pos(door_pos + steps);
               past_end = opening ? (door_pos < travel_lim) : (door_pos > 0);
               d = cnt - ref_cnt;
               if (d < 0) d = -d;
               elapsed = now - move_time;
               if (d >= longint'(cfg_thresh)) begin
                  ref_cnt = cnt;
                  move_time = now;
                  if (past_end) door_st = opening ? dds_pkg::ST_OPEN : dds_pkg::ST_CLOSED;
               end else if (elapsed >= {16'd0, cfg_timeout}) begin
                  r.motor_stop = 1'b1;
                  door_stuck = 1'b1;
                  door_calibrated = 1'b0;
                  door_st = opening ? dds_pkg::ST_OPEN : dds_pkg::ST_CLOSED;
               end else if (past_end) begin
                  door_st = opening ? dds_pkg::ST_OPEN : dds_pkg::ST_CLOSED;
               end
            end
         end
         dds_pkg::MODE_CAL: begin
            offs = longint'(cfg_offset);
            travel_lim = clamp_pos(offs - longint'(cs));
            door_pos = 0;
            door_st = dds_pkg::ST_CLOSED;
            prev_end = dds_pkg::ST_CLOSED;
            door_calibrated = 1'b1;
            ref_cnt = 0;
            r.encoder_clear = 1'b1;
         end
         default: ;
      endcase
      r.motor_steps = steps[10:0];
      r.door_state = door_st;
      r.stuck_flag = door_stuck;
      r.calibrated_flag = door_calibrated;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Request and register drivers
   // ------------------------------------------------------------------

   // Mostly short gaps, a few long ones, none in quiet stretches
   function automatic int pick_gap();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic send_request(input logic [1:0] mode, input logic [23:0] enc,
                               input logic [31:0] t, input logic [19:0] cs);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {4'd0, cs, t, enc};
      do @(posedge clock); while (!req_tready);
      rsp_due.push_back(door_step(mode, enc, t, cs));
   endtask

   // Drain all responses, then write the four registers back to back
   task automatic write_regs(input logic [15:0] th, input logic [15:0] tmo,
                             input logic [9:0] st, input logic [19:0] eo);
      logic [1:0] idx [4];
      logic [19:0] val [4];
      idx[0] = dds_pkg::CSR_MOVE_THRESH;
      idx[1] = dds_pkg::CSR_TIMEOUT;
      idx[2] = dds_pkg::CSR_STEPS;
      idx[3] = dds_pkg::CSR_END_OFFSET;
      val[0] = {4'd0, th};
      val[1] = {4'd0, tmo};
      val[2] = {10'd0, st};
      val[3] = eo;
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      csr_valid <= 1'b1;
      for (int i = 0; i < 4; i++) begin
         csr_index <= idx[i];
         csr_data <= val[i];
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      cfg_thresh = th;
      cfg_timeout = tmo;
      cfg_steps = st;
      cfg_offset = eo;
      @(posedge clock);
   endtask

   // Encoder count that differs from the reference by at least the threshold
   function automatic logic [23:0] moving_count();
      longint span;
      longint v;
      span = longint'(cfg_thresh) + $urandom_range(0, 3);
      v = $urandom_range(0, 1) ? ref_cnt + span : ref_cnt - span;
      if (v > 8388607 || v < -8388608) v = (v > ref_cnt) ? ref_cnt - span : ref_cnt + span;
      return v[23:0];
   endfunction

   // Encoder count that stays within the threshold of the reference
   function automatic logic [23:0] still_count();
      longint span;
      longint v;
      if (cfg_thresh == 0) return ref_cnt[23:0];
      span = $urandom_range(0, int'(cfg_thresh) - 1);
      v = $urandom_range(0, 1) ? ref_cnt + span : ref_cnt - span;
      if (v > 8388607 || v < -8388608) v = (v > ref_cnt) ? ref_cnt - span : ref_cnt + span;
      return v[23:0];
   endfunction

   task automatic tick_moving();
      now_ms = now_ms + $urandom_range(0, 5);
      send_request(dds_pkg::MODE_TICK, moving_count(), now_ms, 20'($urandom));
   endtask

   // Tick with no real movement; with expire set the timeout is run out
   task automatic tick_still(input bit expire);
      if (expire)
         now_ms = move_time + cfg_timeout + $urandom_range(0, 20);
      else
         now_ms = now_ms + $urandom_range(0, 3);
      send_request(dds_pkg::MODE_TICK, still_count(), now_ms, 20'($urandom));
   endtask

   task automatic press_toggle();
      send_request(dds_pkg::MODE_TOGGLE, ref_cnt[23:0], now_ms, 20'($urandom));
   endtask

   task automatic calibrate(input logic [19:0] cs);
      send_request(dds_pkg::MODE_CAL, 24'($urandom), now_ms, cs);
   endtask

   // Tick with movement until the move ends
   task automatic run_to_rest();
      while (door_st == dds_pkg::ST_OPENING || door_st == dds_pkg::ST_CLOSING)
         tick_moving();
   endtask

   // Closing count that leaves a short opening travel, now and then anything
   function automatic logic [19:0] pick_close_steps();
      longint v;
      if ($urandom_range(0, 9) == 0) return 20'($urandom);
      v = longint'(cfg_offset) + longint'(cfg_steps) * $urandom_range(0, 5)
          + $urandom_range(0, int'(cfg_steps));
      if (v > 20'hFFFFF) v = 20'hFFFFF;
      return v[19:0];
   endfunction

   // Any kind, any content
   task automatic send_noise();
      logic [1:0] mode;
      mode = 2'($urandom_range(0, 3));
      now_ms = $urandom;
      send_request(mode, 24'($urandom), now_ms, 20'($urandom));
   endtask

   // ------------------------------------------------------------------
   // Directed tests
   // ------------------------------------------------------------------

   // Toggle ignored before calibration, idle ticks, field extremes
   task automatic test_before_calibration();
      send_request(dds_pkg::MODE_TOGGLE, 24'h7FFFFF, 32'hFFFFFFFF, 20'hFFFFF);
      send_request(dds_pkg::MODE_TICK, 24'h800000, 32'h0, 20'h0);
      send_request(MODE_NONE, 24'h7FFFFF, 32'hFFFFFFFF, 20'hFFFFF);
   endtask

   // Full open and close cycle at the reset register values
   task automatic test_open_close();
      now_ms = 32'd100;
      calibrate(20'd748);
      press_toggle();
      run_to_rest();
      press_toggle();
      run_to_rest();
   endtask

   // Stop while opening, then resume toward the closed end the door last left
   task automatic test_stop_resume();
      press_toggle();
      press_toggle();
      press_toggle();
      run_to_rest();
   endtask

   // Limit above the position: opening ends on the start itself
   task automatic test_start_no_travel();
      calibrate(20'd732);
      press_toggle();
   endtask

   // Stall while closing drops calibration; later toggles are ignored
   task automatic test_stall();
      press_toggle();
      tick_still(1'b1);
      press_toggle();
   endtask

   // Zero timeout stalls at once; zero steps never reach the end
   task automatic test_zero_timeout_steps();
      write_regs(16'd4, 16'd0, 10'd0, 20'd740);
      calibrate(20'd748);
      press_toggle();
      tick_still(1'b0);
      calibrate(20'd748);
      press_toggle();
      tick_moving();
      press_toggle();
   endtask

   // ------------------------------------------------------------------
   // Random sequences over several register settings
   // ------------------------------------------------------------------
   task automatic test_random_sequences();
      int r;
      for (int p = 0; p < 8; p++) begin
         case (p)
            0: write_regs(dds_pkg::MOVE_THRESH_RST, dds_pkg::TIMEOUT_RST,
                          dds_pkg::STEPS_RST, dds_pkg::END_OFFSET_RST);
            1: write_regs(16'd0, 16'd1, 10'd1, 20'd0);
            2: write_regs(16'hFFFF, 16'hFFFF, 10'h3FF, 20'hFFFFF);
            3: write_regs(16'd1, 16'd0, 10'h3FF, 20'd0);
            default: write_regs(16'($urandom_range(0, 40)), 16'($urandom_range(1, 200)),
                                10'($urandom_range(1, 1023)), 20'($urandom));
         endcase
         quiet = (p == 3 || p == 6);
         if (p == 5) now_ms = 32'hFFFFFFF0;
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            r = $urandom_range(0, 99);
            if (door_st == dds_pkg::ST_OPENING || door_st == dds_pkg::ST_CLOSING) begin
               if (r < 78) tick_moving();
               else if (r < 86) tick_still(1'b0);
               else if (r < 91) tick_still(1'b1);
               else if (r < 97) press_toggle();
               else calibrate(pick_close_steps());
            end else if (!door_calibrated) begin
               if (r < 50) calibrate(pick_close_steps());
               else if (r < 70) press_toggle();
               else send_noise();
            end else begin
               if (r < 60) press_toggle();
               else if (r < 72) tick_still(1'b0);
               else if (r < 78) calibrate(pick_close_steps());
               else send_noise();
            end
         end
      end
      quiet = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Response checking
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input longint got, input longint want);
      error_count++;
      $display("[%0t] %s mismatch: got %0d expected %0d", $realtime, what, got, want);
   endtask

   // Compare each taken response, then pick the ready for the next cycle
   always @(posedge clock) begin
      dds_pkg::rsp_type got;
      dds_pkg::rsp_type want;
      if (!reset && rsp_tvalid === 1'b1 && rsp_tready) begin
         got = rsp_tdata[17:0];
         if (rsp_due.size() == 0) begin
            report_mismatch("unexpected response", rsp_tdata, 0);
         end else begin
            want = rsp_due.pop_front();
            if (got.motor_steps !== want.motor_steps)
               report_mismatch("motor_steps", got.motor_steps, want.motor_steps);
            if (got.motor_stop !== want.motor_stop)
               report_mismatch("motor_stop", got.motor_stop, want.motor_stop);
            if (got.encoder_clear !== want.encoder_clear)
               report_mismatch("encoder_clear", got.encoder_clear, want.encoder_clear);
            if (got.door_state !== want.door_state)
               report_mismatch("door_state", got.door_state, want.door_state);
            if (got.stuck_flag !== want.stuck_flag)
               report_mismatch("stuck_flag", got.stuck_flag, want.stuck_flag);
            if (got.calibrated_flag !== want.calibrated_flag)
               report_mismatch("calibrated_flag", got.calibrated_flag, want.calibrated_flag);
            if (rsp_tdata[dds_pkg::RSP_DATA_BITS-1:18] !== '0)
               report_mismatch("padding", rsp_tdata[dds_pkg::RSP_DATA_BITS-1:18], 0);
         end
      end
      if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left--;
      end else begin
         rsp_tready <= 1'b1;
         if (!quiet && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_before_calibration();
      test_open_close();
      test_stop_resume();
      test_start_no_travel();
      test_stall();
      test_zero_timeout_steps();
      test_random_sequences();
      req_tvalid <= 1'b0;
      while (rsp_due.size() != 0) @(posedge clock);
      repeat (6) @(posedge clock);
      if (error_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
